// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the voice RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is low
`define FMV_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds through reset
`define FMV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fmv_pkg.sv =====
// Package: types, constants and control codes of the FM voice
`timescale 1ns / 1ps
package fmv_pkg;

    // Parameter defaults
    localparam int SINE_DEPTH_DEF  = 1024;
    localparam int PHASE_BITS_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 16;

    // Field and register widths
    localparam int SMP_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MDEPTH_W   = 24;
    localparam int AMP_W      = 16;
    localparam int DECAY_W    = 16;
    localparam int LEN_W      = 24;
    localparam int ENV_W      = 17;
    localparam int DEP_W      = 25;
    localparam int ROM_W      = 15;

    localparam logic [ENV_W-1:0]   ENV_ONE     = 17'h10000;
    localparam logic [DECAY_W-1:0] DECAY_RESET = 16'hFFFF;

    // Shared multiplier operand/product widths
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CARRIER_INC = 3'd0,
        CFG_MOD_INC     = 3'd1,
        CFG_MOD_DEPTH   = 3'd2,
        CFG_AMPLITUDE   = 3'd3,
        CFG_DECAY       = 3'd4,
        CFG_NOTE_LEN    = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_MOD_IDX,
        ST_MOD_ROM,
        ST_MOD_SIN,
        ST_OFFSET,
        ST_ARG,
        ST_CAR_IDX,
        ST_CAR_ROM,
        ST_CAR_SIN,
        ST_SIN_ENV,
        ST_VOICE,
        ST_ENV_UPD,
        ST_OUT
    } t_state;

    // Operand pairs for the shared multiplier
    typedef enum logic [2:0] {
        MS_MOD_IDX,
        MS_DEPTH,
        MS_INNER,
        MS_CAR_IDX,
        MS_SIN_ENV,
        MS_AMP,
        MS_ENV_DECAY
    } t_mul_sel;

    typedef struct packed {
        logic     in_ready;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     rom_load;
        logic     depth_load;
        logic     arg_load;
        logic     voice_load;
        logic     voice_clear;
        logic     note_step;
        logic     out_load;
    } t_seq_ctrl;

endpackage

// ===== rtl/fmv_in_if.sv =====
// Input request channel: mix samples plus note control
`timescale 1ns / 1ps
interface fmv_in_if import fmv_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] left_in;
    logic signed [SMP_W-1:0] right_in;
    logic                    restart;
    logic                    block_end;

    modport source (output valid, left_in, right_in, restart, block_end, input ready);
    modport sink   (input valid, left_in, right_in, restart, block_end, output ready);
endinterface

// ===== rtl/fmv_out_if.sv =====
// Output request channel: mixed samples plus status
`timescale 1ns / 1ps
interface fmv_out_if import fmv_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] left_out;
    logic signed [SMP_W-1:0] right_out;
    logic                    sounding;
    logic                    block_last;

    modport source (output valid, left_out, right_out, sounding, block_last, input ready);
    modport sink   (input valid, left_out, right_out, sounding, block_last, output ready);
endinterface

// ===== rtl/fm_two_operator_voice_top.sv =====
// Top level of the two-operator FM voice mixed into a stereo stream
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Two-operator FM voice. Every stereo sample taken on i_in gets
// sin(carrier + depth*env*sin(modulator)) * env * amplitude added to both
// channels, saturated to SAMPLE_BITS and returned on o_out in the same order.
// Six registers are written through i_cfg_we/i_cfg_idx/i_cfg_data (index 0
// carrier increment, 1 modulator increment, 2 modulation depth Q8.16,
// 3 amplitude Q1.15, 4 decay factor Q0.16, 5 note length); write them only
// while no request is in flight. Setting restart on a request zeroes both
// phases and the sample position and sets the envelope to unity before that
// sample is voiced; once note_length samples have sounded, requests pass
// through with sounding low. A sounding sample is worked through the single
// 34x18 multiplier, used seven times per sample (two sine indexes, depth,
// offset, two gain products, envelope decay), and through two reads of the
// registered quarter-wave ROM; a pass-through sample uses neither of them.
// A result sits in an output register, so the next request is taken while it
// waits; the block stalls at the end of that request only if the result is
// still untaken. Reset is synchronous, active low; no clearing pass is needed.
module fm_two_operator_voice_top import fmv_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
    parameter int PHASE_BITS       = PHASE_BITS_DEF,
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    fmv_in_if.sink                i_in,
    fmv_out_if.source             o_out
);

    localparam int QUARTER = SINE_TABLE_DEPTH / 4;
    localparam int N4      = 4 * QUARTER;
    localparam int IDX_W   = $clog2(N4);
    localparam int PS      = 32 - PHASE_BITS;       // offset scale to phase units
    localparam int VS      = 47 - SAMPLE_BITS;      // voice product scale
    localparam int VOICE_W = SAMPLE_BITS + 1;
    localparam int SUM_W   = (SAMPLE_BITS + 2 > SMP_W + 1) ? SAMPLE_BITS + 2 : SMP_W + 1;

    localparam logic signed [SUM_W-1:0] SMAX = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SMIN = -SMAX - SUM_W'(1);

    // Config registers
    logic [PHASE_BITS-1:0] r_cinc;
    logic [PHASE_BITS-1:0] r_minc;
    logic [MDEPTH_W-1:0]   r_mdepth;
    logic [AMP_W-1:0]      r_amp;
    logic [DECAY_W-1:0]    r_decay;
    logic [LEN_W-1:0]      r_len;

    // Note state
    logic [PHASE_BITS-1:0] r_cphase;
    logic [PHASE_BITS-1:0] r_mphase;
    logic [LEN_W-1:0]      r_pos;
    logic [ENV_W-1:0]      r_env;

    // Per-sample working registers
    logic signed [SMP_W-1:0]   r_lin;
    logic signed [SMP_W-1:0]   r_rin;
    logic                      r_blk;
    logic [DEP_W-1:0]          r_depth;
    logic [PHASE_BITS-1:0]     r_arg;
    logic signed [VOICE_W-1:0] r_voice;
    logic                      r_sounding;

    // Output register
    logic                    r_out_valid;
    logic signed [SMP_W-1:0] r_out_l;
    logic signed [SMP_W-1:0] r_out_r;
    logic                    r_out_snd;
    logic                    r_out_blk;

    t_seq_ctrl                 w_ctrl;
    logic                      w_in_accept;
    logic                      w_out_free;
    logic                      w_active;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [MUL_P_W-1:0] r_prod;
    logic signed [MUL_P_W-1:0] w_off;
    logic signed [MUL_P_W-1:0] w_u;
    logic signed [SMP_W-1:0]   w_sine;
    logic [IDX_W-1:0]          w_idx;
    logic signed [SUM_W-1:0]   w_lsum;
    logic signed [SUM_W-1:0]   w_rsum;

    function automatic logic [SMP_W-1:0] sat_sample(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        if (v > SMAX) begin
            c = SMAX;
        end else if (v < SMIN) begin
            c = SMIN;
        end else begin
            c = v;
        end
        return c[SMP_W-1:0];
    endfunction

    assign w_in_accept = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_active    = r_pos < r_len;
    assign i_in.ready  = w_ctrl.in_ready;

    fmv_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_active   (w_active),
        .i_out_free (w_out_free),
        .o_ctrl     (w_ctrl)
    );

    // Operand select for the shared multiplier
    always_comb begin
        unique case (w_ctrl.mul_sel)
            MS_MOD_IDX: begin
                w_mul_a = MUL_A_W'(r_mphase);
                w_mul_b = MUL_B_W'(N4);
            end
            MS_DEPTH: begin
                w_mul_a = MUL_A_W'(r_mdepth);
                w_mul_b = MUL_B_W'(r_env);
            end
            MS_INNER: begin
                w_mul_a = MUL_A_W'(r_depth);
                w_mul_b = MUL_B_W'(w_sine);
            end
            MS_CAR_IDX: begin
                w_mul_a = MUL_A_W'(r_arg);
                w_mul_b = MUL_B_W'(N4);
            end
            MS_SIN_ENV: begin
                w_mul_a = MUL_A_W'(w_sine);
                w_mul_b = MUL_B_W'(r_env);
            end
            MS_AMP: begin
                w_mul_a = r_prod[MUL_A_W-1:0];
                w_mul_b = MUL_B_W'(r_amp);
            end
            MS_ENV_DECAY: begin
                w_mul_a = MUL_A_W'(r_env);
                w_mul_b = MUL_B_W'(r_decay);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    fmv_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_ctrl.mul_en),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (r_prod)
    );

    // Table index is the top bits of phase * table size
    assign w_idx = r_prod[PHASE_BITS +: IDX_W];

    fmv_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_rom (
        .i_clk  (i_clk),
        .i_load (w_ctrl.rom_load),
        .i_idx  (w_idx),
        .o_sine (w_sine)
    );

    // Modulation offset: 2*depth*sin floored into phase units
    assign w_off = r_prod <<< 1;
    assign w_u   = w_off >>> PS;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cinc   <= '0;
            r_minc   <= '0;
            r_mdepth <= '0;
            r_amp    <= '0;
            r_decay  <= DECAY_RESET;
            r_len    <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CARRIER_INC: r_cinc   <= i_cfg_data[PHASE_BITS-1:0];
                CFG_MOD_INC:     r_minc   <= i_cfg_data[PHASE_BITS-1:0];
                CFG_MOD_DEPTH:   r_mdepth <= i_cfg_data[MDEPTH_W-1:0];
                CFG_AMPLITUDE:   r_amp    <= i_cfg_data[AMP_W-1:0];
                CFG_DECAY:       r_decay  <= i_cfg_data[DECAY_W-1:0];
                CFG_NOTE_LEN:    r_len    <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Note state: reset on an accepted restart request, advance after a voiced sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cphase <= '0;
            r_mphase <= '0;
            r_pos    <= '0;
            r_env    <= ENV_ONE;
        end else if (w_in_accept && i_in.restart) begin
            r_cphase <= '0;
            r_mphase <= '0;
            r_pos    <= '0;
            r_env    <= ENV_ONE;
        end else if (w_ctrl.note_step) begin
            r_cphase <= r_cphase + r_cinc;
            r_mphase <= r_mphase + r_minc;
            r_pos    <= r_pos + LEN_W'(1);
            r_env    <= r_prod[16 +: ENV_W];
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_lin <= i_in.left_in;
            r_rin <= i_in.right_in;
            r_blk <= i_in.block_end;
        end
        if (w_ctrl.depth_load) begin
            r_depth <= r_prod[16 +: DEP_W];
        end
        if (w_ctrl.arg_load) begin
            r_arg <= r_cphase + w_u[PHASE_BITS-1:0];
        end
        if (w_ctrl.voice_clear) begin
            r_voice    <= '0;
            r_sounding <= 1'b0;
        end else if (w_ctrl.voice_load) begin
            r_voice    <= r_prod[VS +: VOICE_W];
            r_sounding <= 1'b1;
        end
    end

    // Mix and saturate
    assign w_lsum = SUM_W'(r_lin) + SUM_W'(r_voice);
    assign w_rsum = SUM_W'(r_rin) + SUM_W'(r_voice);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.out_load) begin
            r_out_l   <= sat_sample(w_lsum);
            r_out_r   <= sat_sample(w_rsum);
            r_out_snd <= r_sounding;
            r_out_blk <= r_blk;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.left_out   = r_out_l;
    assign o_out.right_out  = r_out_r;
    assign o_out.sounding   = r_out_snd;
    assign o_out.block_last = r_out_blk;

    `FMV_ASSERT(a_busy_after_accept, i_clk, i_rst_n, (i_in.valid && i_in.ready) |=> !i_in.ready, "request taken while busy")
    `FMV_ASSERT(a_out_from_load, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(w_ctrl.out_load), "result without load")
    `FMV_ASSERT(a_env_bound, i_clk, i_rst_n, r_env <= ENV_ONE, "envelope above unity")

endmodule

// ===== rtl/fmv_mul.sv =====
// Shared signed multiplier with registered product
`timescale 1ns / 1ps
module fmv_mul import fmv_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_p
);

    logic signed [MUL_P_W-1:0] w_a;
    logic signed [MUL_P_W-1:0] w_b;
    logic signed [MUL_P_W-1:0] r_p;

    assign w_a = MUL_P_W'(i_a);
    assign w_b = MUL_P_W'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= w_a * w_b;
        end
    end

    assign o_p = r_p;

endmodule

// ===== rtl/fmv_sine_rom.sv =====
// Quarter-wave sine ROM with quadrant fold and registered read
`timescale 1ns / 1ps
module fmv_sine_rom import fmv_pkg::*; #(
    parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
    localparam int QUARTER = SINE_TABLE_DEPTH / 4,
    localparam int IDX_W   = $clog2(4 * QUARTER),
    localparam int ADDR_W  = $clog2(QUARTER + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_load,
    input  logic [IDX_W-1:0]        i_idx,
    output logic signed [SMP_W-1:0] o_sine
);

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

    localparam logic [IDX_W:0] Q1 = (IDX_W + 1)'(QUARTER);
    localparam logic [IDX_W:0] Q2 = (IDX_W + 1)'(2 * QUARTER);
    localparam logic [IDX_W:0] Q3 = (IDX_W + 1)'(3 * QUARTER);
    localparam logic [IDX_W:0] Q4 = (IDX_W + 1)'(4 * QUARTER);

    // Taylor series to x^11 in Q30, rounded to Q1.15
    function automatic logic [ROM_W-1:0] sine_q15(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] q;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
        t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
        s  = (x * t) >> 30;
        q  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q[ROM_W-1:0];
    endfunction

    logic [ROM_W-1:0] w_rom [QUARTER+1];

    for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
        localparam logic [63:0] X =
            (64'(k) * HALF_PI_Q30 + 64'(QUARTER / 2)) / 64'(QUARTER);
        localparam logic [ROM_W-1:0] V = sine_q15(X);
        assign w_rom[k] = V;
    end

    logic [IDX_W:0]    w_ix;
    logic [IDX_W:0]    w_addr_x;
    logic              w_neg;
    logic [ADDR_W-1:0] r_addr;
    logic              r_neg;
    logic              r_neg_d;
    logic [ROM_W-1:0]  r_data;
    logic signed [SMP_W-1:0] w_mag;

    // Fold the full-cycle index onto the quarter wave
    always_comb begin
        w_ix = {1'b0, i_idx};
        priority if (w_ix < Q1) begin
            w_addr_x = w_ix;
            w_neg    = 1'b0;
        end else if (w_ix < Q2) begin
            w_addr_x = Q2 - w_ix;
            w_neg    = 1'b0;
        end else if (w_ix < Q3) begin
            w_addr_x = w_ix - Q2;
            w_neg    = 1'b1;
        end else begin
            w_addr_x = Q4 - w_ix;
            w_neg    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_addr <= w_addr_x[ADDR_W-1:0];
            r_neg  <= w_neg;
        end
        r_data  <= w_rom[r_addr];
        r_neg_d <= r_neg;
    end

    assign w_mag  = {1'b0, r_data};
    assign o_sine = r_neg_d ? -w_mag : w_mag;

endmodule

// ===== rtl/fmv_seq.sv =====
// Sequencer stepping one sample through the shared multiplier
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fmv_seq import fmv_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_active,
    input  logic      i_out_free,
    output t_seq_ctrl o_ctrl
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (i_in_valid) n_state = ST_START;
            ST_START:   n_state = i_active ? ST_MOD_IDX : ST_OUT;
            ST_MOD_IDX: n_state = ST_MOD_ROM;
            ST_MOD_ROM: n_state = ST_MOD_SIN;
            ST_MOD_SIN: n_state = ST_OFFSET;
            ST_OFFSET:  n_state = ST_ARG;
            ST_ARG:     n_state = ST_CAR_IDX;
            ST_CAR_IDX: n_state = ST_CAR_ROM;
            ST_CAR_ROM: n_state = ST_CAR_SIN;
            ST_CAR_SIN: n_state = ST_SIN_ENV;
            ST_SIN_ENV: n_state = ST_VOICE;
            ST_VOICE:   n_state = ST_ENV_UPD;
            ST_ENV_UPD: n_state = ST_OUT;
            ST_OUT:     if (i_out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl         = '0;
        o_ctrl.mul_sel = MS_MOD_IDX;
        unique case (r_state)
            ST_IDLE: begin
                o_ctrl.in_ready = 1'b1;
            end
            ST_START: begin
                o_ctrl.mul_en      = i_active;
                o_ctrl.mul_sel     = MS_MOD_IDX;
                o_ctrl.voice_clear = !i_active;
            end
            ST_MOD_IDX: begin
                o_ctrl.rom_load = 1'b1;
                o_ctrl.mul_en   = 1'b1;
                o_ctrl.mul_sel  = MS_DEPTH;
            end
            ST_MOD_ROM: begin
                o_ctrl.depth_load = 1'b1;
            end
            ST_MOD_SIN: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = MS_INNER;
            end
            ST_OFFSET: begin
                o_ctrl.arg_load = 1'b1;
            end
            ST_ARG: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = MS_CAR_IDX;
            end
            ST_CAR_IDX: begin
                o_ctrl.rom_load = 1'b1;
            end
            ST_CAR_ROM: begin
            end
            ST_CAR_SIN: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = MS_SIN_ENV;
            end
            ST_SIN_ENV: begin
                o_ctrl.mul_en  = 1'b1;
                o_ctrl.mul_sel = MS_AMP;
            end
            ST_VOICE: begin
                o_ctrl.voice_load = 1'b1;
                o_ctrl.mul_en     = 1'b1;
                o_ctrl.mul_sel    = MS_ENV_DECAY;
            end
            ST_ENV_UPD: begin
                o_ctrl.note_step = 1'b1;
            end
            ST_OUT: begin
                o_ctrl.out_load = i_out_free;
            end
            default: begin
            end
        endcase
    end

    `FMV_ASSERT(a_out_stall_holds, i_clk, i_rst_n, (r_state == ST_OUT && !i_out_free) |=> (r_state == ST_OUT), "result dropped while output busy")
    `FMV_ASSERT_ALWAYS(a_reset_to_idle, i_clk, !$past(i_rst_n) |-> (r_state == ST_IDLE), "sequencer not idle after reset")

endmodule
